/* design/tbsh_pkg.sv */
// Package for the tagged byte-stream hash core.
// Holds the shared types, the request codes, the hash constants and the tag helper.
// No dependencies; every design file imports it.
`default_nettype none

package tbsh_pkg;

   typedef logic [31:0] hash_word_type;
   typedef logic [7:0]  byte_type;
   typedef logic [4:0]  offset_type;
   typedef logic [1:0]  req_code_type;
   typedef logic [1:0]  byte_idx_type;

   // Request codes carried on req_type
   localparam req_code_type REQ_STRING  = 2'd0;
   localparam req_code_type REQ_BINARY  = 2'd1;
   localparam req_code_type REQ_NUMERAL = 2'd2;

   localparam hash_word_type SEED_HASH     = 32'h1afe21c5;
   localparam offset_type    OFFSET_STEP   = 5'd5;
   localparam hash_word_type SMALL_LIMIT   = 32'h10000000;
   localparam hash_word_type SMALL_TAG     = 32'h10000000;
   localparam hash_word_type NUMERAL_MASK  = 32'h1fffffff;
   localparam hash_word_type NUMERAL_TAG   = 32'h20000000;
   localparam hash_word_type STRING_TAG    = 32'h80000000;
   localparam hash_word_type BINARY_MASK   = 32'h3fffffff;
   localparam hash_word_type BINARY_TAG    = 32'h40000000;
   localparam byte_idx_type  LAST_BYTE_IDX = 2'd3;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_MIX,
      ST_OUT
   } state_type;

   // Finalize a message hash with the tag of its closing request
   function automatic hash_word_type tag_message(hash_word_type h, req_code_type code);
      hash_word_type tag_word;
      if (code == REQ_STRING) begin
         tag_word = h | STRING_TAG;
      end else begin
         tag_word = (h & BINARY_MASK) | BINARY_TAG;
      end
      return tag_word;
   endfunction

endpackage

`default_nettype wire

/* design/tagged_byte_stream_hash_core.sv */
// Tagged byte-stream hash core: a message fed one byte per item, or one 32-bit numeral per
// item, becomes a 32-bit key with a type tag in its top bits. A message byte passes through
// the shared multiply/mix unit in ST_MUL and then ST_MIX (multiply, then mix) before the
// core takes the next byte; a byte that ends a message then goes to ST_OUT to place the
// result. A numeral of 2^28 or more runs its four bytes through the same unit, each byte in
// ST_MUL then ST_MIX, and then goes to ST_OUT; a small numeral or an empty request goes
// straight to ST_OUT. The single multiplier serves messages and numerals alike. The core
// stays in ST_OUT while the output register still holds an earlier result under rsp_stall.
// The core takes no item while an item is in flight, but
// once a result sits in the output register it accepts the next item even while rsp_stall
// holds it. req_type 3 is dropped without effect.
`default_nettype none

module tagged_byte_stream_hash_core (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  tbsh_pkg::req_code_type  req_type,
   input  tbsh_pkg::byte_type      req_byte_value,
   input  tbsh_pkg::hash_word_type req_number,
   input  wire                     req_last,
   input  wire                     req_empty_req,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output tbsh_pkg::hash_word_type rsp_hash
);
   import tbsh_pkg::*;

   state_type     state_ff, state_in;
   hash_word_type run_hash_ff, run_hash_in;
   offset_type    run_off_ff, run_off_in;
   hash_word_type work_hash_ff, work_hash_in;
   hash_word_type data_ff, data_in;
   offset_type    op_off_ff, op_off_in;
   byte_idx_type  byte_idx_ff, byte_idx_in;
   logic          is_num_ff, is_num_in;
   logic          last_ff, last_in;
   req_code_type  code_ff, code_in;
   hash_word_type result_ff, result_in;
   logic          rsp_valid_ff, rsp_valid_in;
   hash_word_type rsp_hash_ff, rsp_hash_in;

   logic          req_accept;
   logic          out_free;
   logic          mul_en;
   hash_word_type unit_hash;
   hash_word_type unit_next;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hash   = rsp_hash_ff;

   // Operand for the shared unit: numeral work hash or message hash
   assign unit_hash = is_num_ff ? work_hash_ff : run_hash_ff;

   tbsh_absorb u_absorb (
      .clock     (clock),
      .mul_en    (mul_en),
      .hash_val  (unit_hash),
      .byte_val  (data_ff[7:0]),
      .offset    (op_off_ff),
      .hash_next (unit_next)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_type)
                  REQ_NUMERAL: state_in = (req_number < SMALL_LIMIT) ? ST_OUT : ST_MUL;
                  REQ_STRING,
                  REQ_BINARY:  state_in = req_empty_req ? ST_OUT : ST_MUL;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL: state_in = ST_MIX;
         ST_MIX: begin
            if (is_num_ff) begin
               state_in = (byte_idx_ff == LAST_BYTE_IDX) ? ST_OUT : ST_MUL;
            end else begin
               state_in = last_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_OUT: state_in = out_free ? ST_IDLE : ST_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control and register next values
   always_comb begin
      run_hash_in  = run_hash_ff;
      run_off_in   = run_off_ff;
      work_hash_in = work_hash_ff;
      data_in      = data_ff;
      op_off_in    = op_off_ff;
      byte_idx_in  = byte_idx_ff;
      is_num_in    = is_num_ff;
      last_in      = last_ff;
      code_in      = code_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      mul_en       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_type)
                  REQ_NUMERAL: begin
                     // Small numerals need no hashing
                     result_in    = SMALL_TAG | req_number;
                     work_hash_in = SEED_HASH;
                     data_in      = req_number;
                     op_off_in    = '0;
                     byte_idx_in  = '0;
                     is_num_in    = 1'b1;
                  end
                  REQ_STRING,
                  REQ_BINARY: begin
                     code_in   = req_type;
                     last_in   = req_last;
                     is_num_in = 1'b0;
                     data_in   = {24'd0, req_byte_value};
                     op_off_in = run_off_ff;
                     if (req_empty_req) begin
                        // Finalize the message as it stands and start over
                        result_in   = tag_message(run_hash_ff, req_type);
                        run_hash_in = SEED_HASH;
                        run_off_in  = '0;
                     end
                  end
                  default: begin
                     // Drop the unused code
                     result_in = result_ff;
                  end
               endcase
            end
         end
         ST_MUL: begin
            mul_en = 1'b1;
         end
         ST_MIX: begin
            if (is_num_ff) begin
               // Advance to the next little-endian byte of the numeral
               work_hash_in = unit_next;
               data_in      = data_ff >> 8;
               op_off_in    = op_off_ff + OFFSET_STEP;
               byte_idx_in  = byte_idx_ff + 2'd1;
               result_in    = (unit_next & NUMERAL_MASK) | NUMERAL_TAG;
            end else if (last_ff) begin
               result_in   = tag_message(unit_next, code_ff);
               run_hash_in = SEED_HASH;
               run_off_in  = '0;
            end else begin
               run_hash_in = unit_next;
               run_off_in  = run_off_ff + OFFSET_STEP;
            end
         end
         ST_OUT: begin
            // Hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = result_ff;
            end
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // Control and message state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         run_hash_ff  <= SEED_HASH;
         run_off_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         run_hash_ff  <= run_hash_in;
         run_off_ff   <= run_off_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      work_hash_ff <= work_hash_in;
      data_ff      <= data_in;
      op_off_ff    <= op_off_in;
      byte_idx_ff  <= byte_idx_in;
      is_num_ff    <= is_num_in;
      last_ff      <= last_in;
      code_ff      <= code_in;
      result_ff    <= result_in;
      rsp_hash_ff  <= rsp_hash_in;
   end

endmodule

`default_nettype wire

/* design/tbsh_absorb.sv */
// Shared absorb unit of the tagged byte-stream hash core.
// Registers the signed byte times hash product, then mixes it back into the hash.
// Depends on tbsh_pkg for the word types.
`default_nettype none

module tbsh_absorb (
   input  wire                     clock,
   input  wire                     mul_en,
   input  tbsh_pkg::hash_word_type hash_val,
   input  tbsh_pkg::byte_type      byte_val,
   input  tbsh_pkg::offset_type    offset,
   output tbsh_pkg::hash_word_type hash_next
);
   import tbsh_pkg::*;

   hash_word_type byte_ext;
   hash_word_type prod_ff;
   hash_word_type prod_in;
   hash_word_type mixed;

   // Sign-extend the byte and keep the low word of the product
   assign byte_ext = {{24{byte_val[7]}}, byte_val};
   assign prod_in  = byte_ext * hash_val;

   // Hold the product for the mix cycle
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Fold left and right shifts of the product; a zero offset gives the product itself
   assign mixed     = (prod_ff << offset) | (prod_ff >> offset);
   assign hash_next = hash_val ^ mixed;

endmodule

`default_nettype wire
